[hdl/chained_hash_table_engine_unit_macros.svh]
// Assertion macros for the chained hash table engine.
// Included by the top level; no other dependencies.
`ifndef CHAINED_HASH_TABLE_ENGINE_UNIT_MACROS_SVH
`define CHAINED_HASH_TABLE_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTH
`define CHTE_ASSERT_NOW(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");
`define CHTE_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");
`else
`define CHTE_ASSERT_NOW(lbl, ck, rst_n, ante, cons)
`define CHTE_ASSERT_NEXT(lbl, ck, rst_n, ante, cons)
`endif
`endif

[hdl/chte_pkg.sv]
// Package for the chained hash table engine: sizes, codes, hash and mask helpers.
// No dependencies.
`default_nettype none
package chte_pkg;

	localparam int BUCKETS         = 16;
	localparam int SLOTS           = 8;
	localparam int KEY_BYTES_MAX   = 8;
	localparam int VALUE_BYTES_MAX = 8;

	localparam int KEY_W     = 64;
	localparam int VALUE_W   = 64;
	localparam int STATUS_W  = 2;
	localparam int REQ_W     = 2;
	localparam int COUNT_W   = 8;
	localparam int CFG_W     = 4;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam int TABLE_DEPTH = BUCKETS * SLOTS;
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int BKT_W       = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int FILL_W      = $clog2(SLOTS + 1) + 1;
	localparam int SUM_W       = 8 + $clog2(KEY_BYTES_MAX + 1);
	localparam int RAM_W       = KEY_W + VALUE_W;

	localparam logic [CFG_W-1:0] KEY_BYTES_RST   = CFG_W'(KEY_BYTES_MAX);
	localparam logic [CFG_W-1:0] VALUE_BYTES_RST = CFG_W'(VALUE_BYTES_MAX);

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_LOOKUP = 2'd1,
		REQ_REMOVE = 2'd2
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} status_t;

	typedef enum logic {
		REG_KEY_BYTES   = 1'b0,
		REG_VALUE_BYTES = 1'b1
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_DISPATCH = 5'b00010,
		ST_SCAN     = 5'b00100,
		ST_SHIFT    = 5'b01000,
		ST_RESP     = 5'b10000
	} state_t;

	function automatic logic [CFG_W-1:0] clamp_bytes(
		input logic [CFG_W-1:0] n,
		input logic [CFG_W-1:0] hi
	);
		logic [CFG_W-1:0] r;
		r = n;
		if (n == '0) begin
			r = CFG_W'(1);
		end else if (n > hi) begin
			r = hi;
		end
		return r;
	endfunction

	function automatic logic [63:0] byte_mask(input logic [CFG_W-1:0] n);
		logic [63:0] m;
		for (int i = 0; i < 8; i++) begin
			m[8*i +: 8] = (CFG_W'(i) < n) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

	function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_W-1:0] k);
		logic [SUM_W-1:0] sum;
		sum = '0;
		for (int i = 0; i < KEY_BYTES_MAX; i++) begin
			sum = sum + SUM_W'(k[8*i +: 8]);
		end
		return BKT_W'(sum % BUCKETS);
	endfunction

endpackage
`default_nettype wire

[hdl/chte_ifs.sv]
// Request and response channel interfaces of the hash table engine.
// Depends on chte_pkg.
`default_nettype none
interface chte_req_if;
	logic                           valid;
	logic                           ready;
	logic [chte_pkg::REQ_W-1:0]     req_type;
	logic [chte_pkg::KEY_W-1:0]     key;
	logic [chte_pkg::VALUE_W-1:0]   value;

	modport source (output valid, output req_type, output key, output value, input ready);
	modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

interface chte_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [chte_pkg::STATUS_W-1:0]  status;
	logic [chte_pkg::VALUE_W-1:0]   value_out;
	logic [chte_pkg::COUNT_W-1:0]   entry_count;

	modport source (output valid, output status, output value_out, output entry_count,
		input ready);
	modport sink   (input valid, input status, input value_out, input entry_count,
		output ready);
endinterface
`default_nettype wire

[hdl/chte_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module chte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[hdl/chained_hash_table_engine_unit.sv]
// Chained hash table engine top level: APB registers, sequencer, bucket fills.
// Depends on chte_pkg, chte_ifs, chte_ram and the assertion macro header.
//
//  channel  dir  handshake        word
//  req      in   valid/ready      req_type, key, value
//  rsp      out  valid/ready      status, value_out, entry_count
//  apb      in   psel/penable     key_bytes @0x0, value_bytes @0x4
//
// Insert, unused code or empty bucket: the result passes DISPATCH and RESP, then the output register.
// Lookup/remove: SCAN reads one slot at a time (up to SLOTS), set by the single
// table read port; remove adds a SHIFT step per entry shifted down.
// Reset clears bucket fills and count and presets the APB registers; no table clearing pass.
// A new word is taken while the previous result waits in the output register;
// the sequencer holds its result until that register frees.
`default_nettype none
`include "chained_hash_table_engine_unit_macros.svh"
module chained_hash_table_engine_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	chte_req_if.sink                             req,
	chte_rsp_if.source                           rsp,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [chte_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [chte_pkg::PDATA_W-1:0]    pwdata,
	output logic      [chte_pkg::PDATA_W-1:0]    prdata,
	output logic                                 pready
);

	chte_pkg::state_t                      state_q, state_d;
	logic [chte_pkg::CFG_W-1:0]            key_bytes_q, value_bytes_q;
	logic [chte_pkg::REQ_W-1:0]            req_q;
	logic [chte_pkg::KEY_W-1:0]            key_q, kmask_q;
	logic [chte_pkg::VALUE_W-1:0]          val_q;
	logic [chte_pkg::BKT_W-1:0]            bkt_q;
	logic [chte_pkg::SLOT_W-1:0]           idx_q, idx_d;
	chte_pkg::status_t                     status_q, status_d;
	logic [chte_pkg::VALUE_W-1:0]          vout_q, vout_d;
	logic [chte_pkg::COUNT_W-1:0]          total_q, total_d;
	logic [chte_pkg::FILL_W-1:0]           fill_q [chte_pkg::BUCKETS];
	logic [chte_pkg::FILL_W-1:0]           fill_cur, fill_wv, idx_p1, idx_p2;
	logic                                  fill_we;
	logic                                  rsp_valid_q;
	logic [chte_pkg::STATUS_W-1:0]         rsp_status_q;
	logic [chte_pkg::VALUE_W-1:0]          rsp_value_q;
	logic [chte_pkg::COUNT_W-1:0]          rsp_count_q;
	logic                                  rsp_load;

	logic                                  in_acc, cfg_wr, hit;
	logic [chte_pkg::CFG_W-1:0]            kb, vb;
	logic [chte_pkg::KEY_W-1:0]            kmask_in, mkey_in;

	logic                                  ram_we;
	logic [chte_pkg::FILL_W-1:0]           wslot, rslot;
	logic [chte_pkg::RAM_W-1:0]            ram_wdata, ram_rdata;
	logic [chte_pkg::ADDR_W-1:0]           ram_waddr, ram_raddr;
	logic [chte_pkg::KEY_W-1:0]            rd_key;
	logic [chte_pkg::VALUE_W-1:0]          rd_val;

	function automatic logic [chte_pkg::ADDR_W-1:0] addr_of(
		input logic [chte_pkg::BKT_W-1:0]  b,
		input logic [chte_pkg::FILL_W-1:0] s
	);
		return chte_pkg::ADDR_W'(b) * chte_pkg::ADDR_W'(chte_pkg::SLOTS)
			+ chte_pkg::ADDR_W'(s);
	endfunction

	// APB registers
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		unique case (chte_pkg::cfg_reg_t'(paddr[2]))
			chte_pkg::REG_KEY_BYTES:   prdata = chte_pkg::PDATA_W'(key_bytes_q);
			chte_pkg::REG_VALUE_BYTES: prdata = chte_pkg::PDATA_W'(value_bytes_q);
			default:                   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_bytes_q   <= chte_pkg::KEY_BYTES_RST;
			value_bytes_q <= chte_pkg::VALUE_BYTES_RST;
		end else if (cfg_wr) begin
			if (chte_pkg::cfg_reg_t'(paddr[2]) == chte_pkg::REG_KEY_BYTES) begin
				key_bytes_q <= pwdata[chte_pkg::CFG_W-1:0];
			end else begin
				value_bytes_q <= pwdata[chte_pkg::CFG_W-1:0];
			end
		end
	end

	// request capture
	assign req.ready = (state_q == chte_pkg::ST_IDLE);
	assign in_acc    = req.valid & req.ready;
	assign kb        = chte_pkg::clamp_bytes(key_bytes_q,
		chte_pkg::CFG_W'(chte_pkg::KEY_BYTES_MAX));
	assign vb        = chte_pkg::clamp_bytes(value_bytes_q,
		chte_pkg::CFG_W'(chte_pkg::VALUE_BYTES_MAX));
	assign kmask_in  = chte_pkg::byte_mask(kb);
	assign mkey_in   = req.key & kmask_in;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q   <= req.req_type;
			key_q   <= mkey_in;
			kmask_q <= kmask_in;
			val_q   <= req.value & chte_pkg::byte_mask(vb);
			bkt_q   <= chte_pkg::bucket_of(mkey_in);
		end
	end

	// table
	assign rd_key    = ram_rdata[chte_pkg::KEY_W-1:0];
	assign rd_val    = ram_rdata[chte_pkg::RAM_W-1:chte_pkg::KEY_W];
	assign ram_waddr = addr_of(bkt_q, wslot);
	assign ram_raddr = addr_of(bkt_q, rslot);

	chte_ram #(
		.WIDTH(chte_pkg::RAM_W),
		.DEPTH(chte_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer
	assign fill_cur = fill_q[bkt_q];
	assign idx_p1   = chte_pkg::FILL_W'(idx_q) + chte_pkg::FILL_W'(1);
	assign idx_p2   = chte_pkg::FILL_W'(idx_q) + chte_pkg::FILL_W'(2);
	assign hit      = ((rd_key ^ key_q) & kmask_q) == '0;

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		status_d  = status_q;
		vout_d    = vout_q;
		total_d   = total_q;
		fill_we   = 1'b0;
		fill_wv   = fill_cur;
		ram_we    = 1'b0;
		wslot     = fill_cur;
		ram_wdata = {val_q, key_q};
		rslot     = idx_p1;
		rsp_load  = 1'b0;
		unique case (state_q)
			chte_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d  = chte_pkg::ST_DISPATCH;
					status_d = chte_pkg::STAT_OK;
					vout_d   = '0;
				end
			end
			chte_pkg::ST_DISPATCH: begin
				rslot = '0;
				idx_d = '0;
				state_d = chte_pkg::ST_RESP;
				unique case (req_q)
					chte_pkg::REQ_INSERT: begin
						if (fill_cur >= chte_pkg::FILL_W'(chte_pkg::SLOTS)) begin
							status_d = chte_pkg::STAT_FULL;
						end else begin
							ram_we  = 1'b1;
							fill_we = 1'b1;
							fill_wv = fill_cur + chte_pkg::FILL_W'(1);
							total_d = total_q + chte_pkg::COUNT_W'(1);
						end
					end
					chte_pkg::REQ_LOOKUP, chte_pkg::REQ_REMOVE: begin
						if (fill_cur == '0) begin
							status_d = chte_pkg::STAT_NOT_FOUND;
						end else begin
							state_d = chte_pkg::ST_SCAN;
						end
					end
					default: ;
				endcase
			end
			chte_pkg::ST_SCAN: begin
				priority if (hit && req_q == chte_pkg::REQ_LOOKUP) begin
					vout_d  = rd_val;
					state_d = chte_pkg::ST_RESP;
				end else if (hit && idx_p1 < fill_cur) begin
					state_d = chte_pkg::ST_SHIFT;
				end else if (hit) begin
					fill_we = 1'b1;
					fill_wv = fill_cur - chte_pkg::FILL_W'(1);
					total_d = total_q - chte_pkg::COUNT_W'(1);
					state_d = chte_pkg::ST_RESP;
				end else if (idx_p1 >= fill_cur) begin
					status_d = chte_pkg::STAT_NOT_FOUND;
					state_d  = chte_pkg::ST_RESP;
				end else begin
					idx_d = chte_pkg::SLOT_W'(idx_p1);
				end
			end
			chte_pkg::ST_SHIFT: begin
				// rdata holds entry idx+1; move it down to idx
				ram_we    = 1'b1;
				wslot     = chte_pkg::FILL_W'(idx_q);
				ram_wdata = ram_rdata;
				rslot     = idx_p2;
				if (idx_p2 < fill_cur) begin
					idx_d = chte_pkg::SLOT_W'(idx_p1);
				end else begin
					fill_we = 1'b1;
					fill_wv = fill_cur - chte_pkg::FILL_W'(1);
					total_d = total_q - chte_pkg::COUNT_W'(1);
					state_d = chte_pkg::ST_RESP;
				end
			end
			chte_pkg::ST_RESP: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = chte_pkg::ST_IDLE;
				end
			end
			default: state_d = chte_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= chte_pkg::ST_IDLE;
			total_q     <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < chte_pkg::BUCKETS; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			total_q <= total_d;
			if (fill_we) begin
				fill_q[bkt_q] <= fill_wv;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		status_q <= status_d;
		vout_q   <= vout_d;
		if (rsp_load) begin
			rsp_status_q <= status_q;
			rsp_value_q  <= vout_q;
			rsp_count_q  <= total_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.value_out   = rsp_value_q;
	assign rsp.entry_count = rsp_count_q;

	`CHTE_ASSERT_NEXT(a_accept_dispatch, clk, arst_n, in_acc, state_q == chte_pkg::ST_DISPATCH)
	`CHTE_ASSERT_NOW(a_we_states, clk, arst_n, ram_we, state_q == chte_pkg::ST_DISPATCH || state_q == chte_pkg::ST_SHIFT)
	`CHTE_ASSERT_NOW(a_fill_bound, clk, arst_n, state_q == chte_pkg::ST_DISPATCH, fill_cur <= chte_pkg::FILL_W'(chte_pkg::SLOTS))
	`CHTE_ASSERT_NOW(a_scan_in_fill, clk, arst_n, state_q == chte_pkg::ST_SCAN, chte_pkg::FILL_W'(idx_q) < fill_cur)

endmodule
`default_nettype wire

[bench/tb_chained_hash_table_engine_unit.sv]
// Testbench for chained_hash_table_engine_unit: random and directed insert/lookup/remove
// words checked field by field against an in-bench model of the bucket table.
// Depends on chte_pkg, chte_ifs and the engine RTL.
`default_nettype none
module tb_chained_hash_table_engine_unit;
	import chte_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int PHASE_ITEMS  = 255;
	localparam int HOLD_CYCLES  = 400;
	localparam int QUIET_CYCLES = 30;
	localparam int TAIL_CYCLES  = 50;
	localparam int STALL_LIMIT  = 3000;
	localparam int MAX_PRINTS   = 40;
	localparam int LIVE_KEEP    = 48;

	typedef struct {
		logic [REQ_W-1:0]   kind;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} req_word_t;

	typedef struct {
		status_t              status;
		logic [VALUE_W-1:0]   value_out;
		logic [COUNT_W-1:0]   count;
	} rsp_word_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	chte_req_if req_if();
	chte_rsp_if rsp_if();

	chained_hash_table_engine_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_if),
		.rsp     (rsp_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// model of the table
	logic [KEY_W-1:0]   tbl_key [BUCKETS][SLOTS];
	logic [VALUE_W-1:0] tbl_val [BUCKETS][SLOTS];
	int                 tbl_fill [BUCKETS];
	logic [COUNT_W-1:0] tbl_total;
	logic [CFG_W-1:0]   key_len;
	logic [CFG_W-1:0]   val_len;

	req_word_t req_backlog[$];
	rsp_word_t answers_due[$];
	logic [KEY_W-1:0] live_keys[$];
	int queued_words;
	int accepted_words;
	int errors;
	int hold_asks;
	int hold_seen;
	int hold_left;
	int burst_left;
	int gap_left;
	int mode_left;
	int tick;
	int idle_cycles;
	logic [1:0] stall_mode;
	rsp_word_t due_front;

	function automatic int clamp_len(input logic [CFG_W-1:0] n, input int hi);
		if (n == 0)
			return 1;
		if (int'(n) > hi)
			return hi;
		return int'(n);
	endfunction

	function automatic logic [63:0] lane_mask(input int n);
		if (n >= 8)
			return '1;
		return (64'd1 << (8 * n)) - 64'd1;
	endfunction

	function automatic rsp_word_t apply_request(input req_word_t w);
		rsp_word_t a;
		logic [KEY_W-1:0] kmask;
		logic [KEY_W-1:0] mkey;
		int kb;
		int vb;
		int sum;
		int b;
		int hit;
		int i;
		kb = clamp_len(key_len, KEY_BYTES_MAX);
		vb = clamp_len(val_len, VALUE_BYTES_MAX);
		kmask = lane_mask(kb);
		mkey = w.key & kmask;
		sum = 0;
		for (i = 0; i < kb; i++)
			sum += int'(mkey[8*i +: 8]);
		b = sum % BUCKETS;
		hit = -1;
		for (i = 0; i < tbl_fill[b]; i++) begin
			if (hit < 0 && ((tbl_key[b][i] ^ mkey) & kmask) == '0)
				hit = i;
		end
		a.status = STAT_OK;
		a.value_out = '0;
		case (w.kind)
			REQ_INSERT: begin
				if (tbl_fill[b] >= SLOTS) begin
					a.status = STAT_FULL;
				end else begin
					tbl_key[b][tbl_fill[b]] = mkey;
					tbl_val[b][tbl_fill[b]] = w.value & lane_mask(vb);
					tbl_fill[b]++;
					tbl_total = tbl_total + 1'b1;
				end
			end
			REQ_LOOKUP: begin
				if (hit < 0)
					a.status = STAT_NOT_FOUND;
				else
					a.value_out = tbl_val[b][hit];
			end
			REQ_REMOVE: begin
				if (hit < 0) begin
					a.status = STAT_NOT_FOUND;
				end else begin
					for (i = hit; i + 1 < tbl_fill[b]; i++) begin
						tbl_key[b][i] = tbl_key[b][i+1];
						tbl_val[b][i] = tbl_val[b][i+1];
					end
					tbl_fill[b]--;
					tbl_total = tbl_total - 1'b1;
				end
			end
			default: ;
		endcase
		a.count = tbl_total;
		return a;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("mismatch %s: got %h want %h", what, got, want);
	endtask

	task automatic push(input logic [REQ_W-1:0] kind, input logic [KEY_W-1:0] key,
			input logic [VALUE_W-1:0] value);
		req_word_t w;
		w.kind = kind;
		w.key = key;
		w.value = value;
		req_backlog.push_back(w);
		queued_words++;
		if (kind == REQ_INSERT) begin
			live_keys.push_back(key);
			if (live_keys.size() > LIVE_KEEP)
				void'(live_keys.pop_front());
		end
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// hot keys land in two buckets whatever key_bytes is
	function automatic logic [KEY_W-1:0] hot_key();
		return KEY_W'(16 * $urandom_range(0, 15) + ($urandom_range(0, 1) ? 5 : 10));
	endfunction

	function automatic logic [KEY_W-1:0] known_key();
		logic [KEY_W-1:0] k;
		if (live_keys.size() == 0)
			return hot_key();
		k = live_keys[$urandom_range(0, live_keys.size() - 1)];
		// upper bytes beyond key_bytes must not matter
		if ($urandom_range(0, 1))
			k = k ^ (rand64() & ~lane_mask(clamp_len(key_len, KEY_BYTES_MAX)));
		return k;
	endfunction

	task automatic gen_items(input int n, input int mix);
		int j;
		int r;
		int ins_lim;
		int look_lim;
		logic [KEY_W-1:0] k;
		logic [VALUE_W-1:0] v;
		ins_lim = (mix == 0) ? 55 : (mix == 1) ? 25 : 40;
		look_lim = (mix == 0) ? 80 : (mix == 1) ? 50 : 70;
		for (j = 0; j < n; j++) begin
			r = $urandom_range(0, 99);
			case ($urandom_range(0, 9))
				0: v = '0;
				1: v = '1;
				default: v = rand64();
			endcase
			if (r < ins_lim) begin
				r = $urandom_range(0, 9);
				k = (r < 5) ? rand64() : (r < 8) ? hot_key() : known_key();
				push(REQ_INSERT, k, v);
			end else begin
				k = ($urandom_range(0, 3) != 0) ? known_key() : rand64();
				if (r < look_lim)
					push(REQ_LOOKUP, k, v);
				else if (r < 97)
					push(REQ_REMOVE, k, v);
				else
					push(REQ_UNUSED, k, v);
			end
		end
	endtask

	task automatic wait_quiet();
		while (accepted_words != queued_words || answers_due.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(r) << 2;
		pwdata <= {$urandom} & ~32'hF | PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (r == REG_KEY_BYTES)
			key_len = v;
		else
			val_len = v;
	endtask

	task automatic check_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= PADDR_W'(r) << 2;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[CFG_W-1:0] !== v)
			report("register readback", 64'(prdata), 64'(v));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		logic [CFG_W-1:0] kb_set [6];
		logic [CFG_W-1:0] vb_set [6];
		logic [CFG_W-1:0] kb;
		logic [CFG_W-1:0] vb;
		int p;
		int j;
		kb_set = '{4'd1, 4'd15, 4'd0, 4'd8, 4'd3, 4'd2};
		vb_set = '{4'd1, 4'd0, 4'd15, 4'd8, 4'd5, 4'd7};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		for (p = 0; p < BUCKETS; p++)
			tbl_fill[p] = 0;
		tbl_total = '0;
		key_len = KEY_BYTES_RST;
		val_len = VALUE_BYTES_RST;
		queued_words = 0;
		accepted_words = 0;
		errors = 0;
		hold_asks = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: empty table, extremes, unused code, bucket full, shift on remove,
		// duplicates
		push(REQ_LOOKUP, '0, '0);
		push(REQ_REMOVE, '1, '0);
		push(REQ_INSERT, '0, '1);
		push(REQ_INSERT, '1, '0);
		push(REQ_LOOKUP, '1, rand64());
		push(REQ_LOOKUP, '0, rand64());
		push(REQ_UNUSED, rand64(), '1);
		for (j = 0; j < SLOTS + 1; j++)
			push(REQ_INSERT, KEY_W'(3 + 16 * j), VALUE_W'(j) | 64'hA5A5_0000_0000_0000);
		push(REQ_REMOVE, KEY_W'(19), '0);
		push(REQ_LOOKUP, KEY_W'(35), '0);
		push(REQ_LOOKUP, KEY_W'(131), '0);
		push(REQ_INSERT, KEY_W'(131), 64'h55);
		push(REQ_LOOKUP, KEY_W'(131), '0);
		push(REQ_INSERT, '0, 64'd5);
		push(REQ_LOOKUP, '0, '0);
		push(REQ_REMOVE, '0, '0);
		push(REQ_LOOKUP, '0, '0);

		for (p = 0; p < 7; p++) begin
			wait_quiet();
			kb = (p < 6) ? kb_set[p] : CFG_W'($urandom_range(0, 15));
			vb = (p < 6) ? vb_set[p] : CFG_W'($urandom_range(0, 15));
			write_reg(REG_KEY_BYTES, kb);
			write_reg(REG_VALUE_BYTES, vb);
			check_reg(REG_KEY_BYTES, kb);
			check_reg(REG_VALUE_BYTES, vb);
			gen_items(PHASE_ITEMS, p % 3);
			if (p == 1 || p == 4)
				hold_asks++;
		end

		wait_quiet();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// request driver: bursts of words with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.req_type <= '0;
			req_if.key <= '0;
			req_if.value <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				answers_due.push_back(apply_request('{req_if.req_type, req_if.key,
					req_if.value}));
				accepted_words++;
			end
			if (!req_if.valid || req_if.ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					req_if.valid <= 1'b0;
				end else if (req_backlog.size() != 0) begin
					req_if.req_type <= req_backlog[0].kind;
					req_if.key <= req_backlog[0].key;
					req_if.value <= req_backlog[0].value;
					void'(req_backlog.pop_front());
					req_if.valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor and ready pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			hold_seen <= 0;
			hold_left <= 0;
			mode_left <= 0;
			stall_mode <= 2'd0;
			tick <= 0;
		end else begin
			tick <= tick + 1;
			if (rsp_if.valid && rsp_if.ready) begin
				if (answers_due.size() == 0) begin
					report("unexpected word", {62'd0, rsp_if.status}, '0);
				end else begin
					due_front = answers_due.pop_front();
					if (rsp_if.status !== due_front.status)
						report("status", 64'(rsp_if.status), 64'(due_front.status));
					if (rsp_if.value_out !== due_front.value_out)
						report("value_out", rsp_if.value_out, due_front.value_out);
					if (rsp_if.entry_count !== due_front.count)
						report("entry_count", 64'(rsp_if.entry_count), 64'(due_front.count));
				end
			end
			if (hold_asks != hold_seen) begin
				hold_seen <= hold_asks;
				hold_left <= HOLD_CYCLES;
				rsp_if.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rsp_if.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					stall_mode <= 2'($urandom_range(0, 3));
					mode_left <= $urandom_range(50, 150);
				end else begin
					mode_left <= mode_left - 1;
				end
				case (stall_mode)
					2'd0: rsp_if.ready <= 1'b1;
					2'd1: rsp_if.ready <= 1'($urandom_range(0, 1));
					2'd2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
					default: rsp_if.ready <= (tick % 3 != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
`default_nettype wire
